// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the resampler RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every rising edge out of reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// cond must never be true at a rising edge out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

// ===== rtl/wtlr_pkg.sv =====
// ---------------------------------------------------------------------------
// wtlr_pkg
// Shared widths, codes and types of the wavetable loop resampler.
// ---------------------------------------------------------------------------
package wtlr_pkg;

	localparam int FRAC_BITS_DEF   = 12;
	localparam int ADDR_BITS_DEF   = 16;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int REQ_W      = 2;
	localparam int WORD_W     = 16;
	localparam int CPOS_W     = 28;
	localparam int STEP_W     = 24;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 28;

	localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_START   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_PRODUCE = 2'd2;

	localparam logic [MODE_W-1:0] MODE_ONESHOT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOOP    = 2'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH_STEP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_END   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_END = 3'd4;

	localparam logic [STEP_W-1:0] PITCH_STEP_RST = 24'd4096;

	// per-word control carried down the interpolation pipe
	typedef struct packed {
		logic valid;     // produce word in this stage
		logic active;    // voice was on: sample is interpolated, else zero
		logic on_after;  // voice state after this word's update
	} wtlr_ctl_t;

endpackage

// ===== rtl/wtlr_wave_mem.sv =====
// ---------------------------------------------------------------------------
// wtlr_wave_mem
// Wave sample memory: one write port, two registered read ports.
// ---------------------------------------------------------------------------
module wtlr_wave_mem #(
	parameter int ADDR_BITS   = 16,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [ADDR_BITS-1:0]          wr_addr,
	input  logic signed [SAMPLE_BITS-1:0] wr_data,
	input  logic                          rd_en,
	input  logic [ADDR_BITS-1:0]          rd_addr_a,
	input  logic [ADDR_BITS-1:0]          rd_addr_b,
	output logic signed [SAMPLE_BITS-1:0] rd_data_a,
	output logic signed [SAMPLE_BITS-1:0] rd_data_b
);

	localparam int DEPTH = 1 << ADDR_BITS;

	logic signed [SAMPLE_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		// read data holds while rd_en is low so a stalled stage keeps it
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

// ===== rtl/wtlr_voice_ctrl.sv =====
// ---------------------------------------------------------------------------
// wtlr_voice_ctrl
// Configuration registers, play position update and memory read issue.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wtlr_voice_ctrl #(
	parameter int FRAC_BITS = 12,
	parameter int ADDR_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [wtlr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wtlr_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             acc_start,
	input  logic                             acc_produce,
	input  logic [wtlr_pkg::CPOS_W-1:0]      start_position,
	input  logic                             s1_en,
	output logic                             rd_en,
	output logic [ADDR_BITS-1:0]             rd_addr_a,
	output logic [ADDR_BITS-1:0]             rd_addr_b,
	output wtlr_pkg::wtlr_ctl_t              ctl_s1,
	output logic [FRAC_BITS-1:0]             frac_s1
);

	import wtlr_pkg::*;

	localparam int POS_BITS = ADDR_BITS + FRAC_BITS;
	// room for sum, reflection and sign at the wider of position and config
	localparam int CW = ((POS_BITS > CPOS_W) ? POS_BITS : CPOS_W) + 3;

	logic [MODE_W-1:0]   mode_q;
	logic [STEP_W-1:0]   step_q;
	logic [CPOS_W-1:0]   lstart_q;
	logic [CPOS_W-1:0]   lend_q;
	logic [CPOS_W-1:0]   send_q;

	logic [POS_BITS-1:0] pos_q;
	logic                back_q;
	logic                playing_q;

	logic [POS_BITS-1:0] pos_d;
	logic                back_d;
	logic                von_d;

	logic signed [CW-1:0] p_x, st_x, ls_x, le_x, se_x;
	logic signed [CW-1:0] fwd_x, rev_x, lp_x, fref_x, rref_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_ONESHOT;
			step_q   <= PITCH_STEP_RST;
			lstart_q <= '0;
			lend_q   <= '0;
			send_q   <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_LOOP_MODE:  mode_q   <= cfg_data[MODE_W-1:0];
				CFG_PITCH_STEP: step_q   <= cfg_data[STEP_W-1:0];
				CFG_LOOP_START: lstart_q <= cfg_data[CPOS_W-1:0];
				CFG_LOOP_END:   lend_q   <= cfg_data[CPOS_W-1:0];
				CFG_SAMPLE_END: send_q   <= cfg_data[CPOS_W-1:0];
				default: ;
			endcase
		end
	end

	assign p_x  = CW'(pos_q);
	assign st_x = CW'(step_q);
	assign ls_x = CW'(lstart_q);
	assign le_x = CW'(lend_q);
	assign se_x = CW'(send_q);

	assign fwd_x  = p_x + st_x;
	assign rev_x  = p_x - st_x;
	assign lp_x   = fwd_x - (le_x - ls_x);
	assign fref_x = le_x + le_x - fwd_x;
	assign rref_x = ls_x + ls_x - rev_x;

	always_comb begin
		pos_d  = pos_q;
		back_d = back_q;
		von_d  = playing_q;
		if (acc_start) begin
			pos_d  = POS_BITS'(start_position);
			back_d = 1'b0;
			von_d  = 1'b1;
		end else if (acc_produce && playing_q) begin
			case (mode_q)
				MODE_ONESHOT: begin
					// past the end: stop and keep the position
					if (fwd_x > se_x) begin
						von_d = 1'b0;
					end else begin
						pos_d = POS_BITS'(fwd_x);
					end
				end
				MODE_LOOP: begin
					pos_d = (fwd_x > le_x) ? POS_BITS'(lp_x) : POS_BITS'(fwd_x);
				end
				default: begin
					// ping-pong, also for the unused mode code
					if (!back_q) begin
						if (fwd_x > le_x) begin
							pos_d  = POS_BITS'(fref_x);
							back_d = 1'b1;
						end else begin
							pos_d = POS_BITS'(fwd_x);
						end
					end else begin
						if (rev_x < ls_x) begin
							pos_d  = POS_BITS'(rref_x);
							back_d = 1'b0;
						end else begin
							pos_d = POS_BITS'(rev_x);
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			back_q    <= 1'b0;
			playing_q <= 1'b0;
		end else begin
			pos_q     <= pos_d;
			back_q    <= back_d;
			playing_q <= von_d;
		end
	end

	// samples are fetched at the position before this word's advance
	assign rd_en     = acc_produce && playing_q;
	assign rd_addr_a = pos_q[POS_BITS-1:FRAC_BITS];
	assign rd_addr_b = rd_addr_a + ADDR_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (s1_en) begin
			ctl_s1 <= '{valid: acc_produce, active: playing_q, on_after: von_d};
		end
	end

	always_ff @(posedge clk) begin
		if (s1_en) begin
			frac_s1 <= pos_q[FRAC_BITS-1:0];
		end
	end

	`ASSERT_PROP(a_voice_off_only_oneshot, clk, arst_n,
		$fell(playing_q) |-> $past(acc_produce) && ($past(mode_q) == MODE_ONESHOT),
		"voice stopped outside a one-shot produce word")
	`ASSERT_PROP(a_s1_holds, clk, arst_n, !s1_en |=> $stable(ctl_s1),
		"stage 1 changed while blocked")
	`ASSERT_NEVER(a_idle_stays_off, clk, arst_n,
		ctl_s1.valid && !ctl_s1.active && ctl_s1.on_after,
		"produce word turned an idle voice on")

endmodule

// ===== rtl/wtlr_interp.sv =====
// ---------------------------------------------------------------------------
// wtlr_interp
// Linear interpolation pipe (multiply, add) and output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wtlr_interp #(
	parameter int FRAC_BITS   = 12,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  wtlr_pkg::wtlr_ctl_t              ctl_s1,
	input  logic [FRAC_BITS-1:0]             frac_s1,
	input  logic signed [SAMPLE_BITS-1:0]    rd_data_a,
	input  logic signed [SAMPLE_BITS-1:0]    rd_data_b,
	output logic                             s1_en,
	input  logic                             out_stall,
	output logic                             out_valid,
	output logic signed [wtlr_pkg::WORD_W-1:0] sample_out,
	output logic                             voice_active
);

	import wtlr_pkg::*;

	localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;

	wtlr_ctl_t                    ctl_s2;
	logic signed [SAMPLE_BITS-1:0] a_s2;
	logic signed [PROD_W-1:0]      prod_s2;

	logic                          out_valid_q;
	logic signed [WORD_W-1:0]      sample_q;
	logic                          voice_active_q;

	logic                          en2, en3;
	logic signed [SAMPLE_BITS:0]   diff_x;
	logic signed [FRAC_BITS:0]     frac_x;
	logic signed [PROD_W-1:0]      prod_x;
	logic signed [PROD_W-1:0]      shr_x;
	logic signed [SAMPLE_BITS-1:0] samp_x;

	// a stage takes a word when it is empty or its word moves on
	assign en3   = !out_valid_q || !out_stall;
	assign en2   = !ctl_s2.valid || en3;
	assign s1_en = !ctl_s1.valid || en2;

	// neighbor only counts with a nonzero fraction
	assign diff_x = (frac_s1 != '0) ?
		($signed({rd_data_b[SAMPLE_BITS-1], rd_data_b}) -
		 $signed({rd_data_a[SAMPLE_BITS-1], rd_data_a})) : '0;
	assign frac_x = $signed({1'b0, frac_s1});
	assign prod_x = diff_x * frac_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en2) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			a_s2    <= rd_data_a;
			prod_s2 <= prod_x;
		end
	end

	// floor shift; the sum lies between the two words so it fits
	assign shr_x  = prod_s2 >>> FRAC_BITS;
	assign samp_x = a_s2 + SAMPLE_BITS'(shr_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en3) begin
			out_valid_q <= ctl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			sample_q       <= ctl_s2.active ? WORD_W'(samp_x) : '0;
			voice_active_q <= ctl_s2.on_after;
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_out   = sample_q;
	assign voice_active = voice_active_q;

	`ASSERT_PROP(a_s1_to_s2, clk, arst_n, (ctl_s1.valid && en2) |=> ctl_s2.valid,
		"word lost between stage 1 and stage 2")
	`ASSERT_PROP(a_s2_to_out, clk, arst_n, (ctl_s2.valid && en3) |=> out_valid_q,
		"word lost between stage 2 and output")

endmodule

// ===== rtl/wavetable_loop_resampler.sv =====
// ---------------------------------------------------------------------------
// wavetable_loop_resampler
// Wavetable voice with linear interpolation and one-shot, loop and
// ping-pong playback.
//
// The block takes one input word per cycle while in_stall is low, of any
// kind, and gives one sample per produce word at that rate while out_stall
// is low; a sample passes stage 1, stage 2 and the output register. The
// play position register is read and advanced in the cycle of acceptance,
// and that edge fetches both neighbor words from the two read ports of the
// wave memory; a multiply stage and an add stage into the output register
// follow. Load words write the memory in the cycle they are taken, and a
// produce word taken in the next cycle already reads the new data. Output
// stall backs up through the stages; input stall rises only when stage 1,
// stage 2 and the output register all hold a produce word and the output
// is stalled. The wave memory is not cleared after reset and must be
// loaded before it is played.
// ---------------------------------------------------------------------------
module wavetable_loop_resampler #(
	parameter int FRAC_BITS   = wtlr_pkg::FRAC_BITS_DEF,
	parameter int ADDR_BITS   = wtlr_pkg::ADDR_BITS_DEF,
	parameter int SAMPLE_BITS = wtlr_pkg::SAMPLE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [wtlr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wtlr_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [wtlr_pkg::REQ_W-1:0]         req_type,
	input  logic [wtlr_pkg::WORD_W-1:0]        word_index,
	input  logic signed [wtlr_pkg::WORD_W-1:0] word_value,
	input  logic [wtlr_pkg::CPOS_W-1:0]        start_position,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [wtlr_pkg::WORD_W-1:0] sample_out,
	output logic                               voice_active
);

	import wtlr_pkg::*;

	logic                          in_acc;
	logic                          acc_load, acc_start, acc_produce;
	logic                          s1_en;
	logic                          rd_en;
	logic [ADDR_BITS-1:0]          rd_addr_a, rd_addr_b;
	logic signed [SAMPLE_BITS-1:0] rd_data_a, rd_data_b;
	wtlr_ctl_t                     ctl_s1;
	logic [FRAC_BITS-1:0]          frac_s1;

	assign in_stall    = !s1_en;
	assign in_acc      = in_valid && !in_stall;
	assign acc_load    = in_acc && (req_type == REQ_LOAD);
	assign acc_start   = in_acc && (req_type == REQ_START);
	assign acc_produce = in_acc && (req_type == REQ_PRODUCE);

	wtlr_wave_mem #(
		.ADDR_BITS   (ADDR_BITS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mem (
		.clk       (clk),
		.wr_en     (acc_load),
		.wr_addr   (ADDR_BITS'(word_index)),
		.wr_data   (SAMPLE_BITS'(word_value)),
		.rd_en     (rd_en),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	wtlr_voice_ctrl #(
		.FRAC_BITS (FRAC_BITS),
		.ADDR_BITS (ADDR_BITS)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.acc_start      (acc_start),
		.acc_produce    (acc_produce),
		.start_position (start_position),
		.s1_en          (s1_en),
		.rd_en          (rd_en),
		.rd_addr_a      (rd_addr_a),
		.rd_addr_b      (rd_addr_b),
		.ctl_s1         (ctl_s1),
		.frac_s1        (frac_s1)
	);

	wtlr_interp #(
		.FRAC_BITS   (FRAC_BITS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_interp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl_s1       (ctl_s1),
		.frac_s1      (frac_s1),
		.rd_data_a    (rd_data_a),
		.rd_data_b    (rd_data_b),
		.s1_en        (s1_en),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.sample_out   (sample_out),
		.voice_active (voice_active)
	);

endmodule

// ===== test/resampler_tb_pkg.sv =====
// ---------------------------------------------------------------------------
// resampler_tb_pkg
// Scoreboard for the wavetable loop resampler: mirrors the voice registers,
// the wave memory and the play state, predicts each produce word's sample
// and checks the sample words that leave the block in order.
// ---------------------------------------------------------------------------
package resampler_tb_pkg;

	localparam int POS_FRAC = wtlr_pkg::FRAC_BITS_DEF;

	// codes the block package leaves unnamed
	localparam logic [wtlr_pkg::MODE_W-1:0] MODE_MIRROR     = 2'd2;
	localparam logic [wtlr_pkg::MODE_W-1:0] MODE_MIRROR_ALT = 2'd3;
	localparam logic [wtlr_pkg::REQ_W-1:0]  REQ_IGNORED     = 2'd3;

	typedef struct {
		logic [15:0] sample;
		logic        active;
	} wave_sample_t;

	class voice_scoreboard;
		wave_sample_t expected_samples[$];
		logic [15:0]  wave_words[int];
		logic [27:0]  pos;
		bit           reverse;
		bit           playing;
		logic [1:0]   play_mode;
		logic [23:0]  pitch;
		logic [27:0]  loop_lo;
		logic [27:0]  loop_hi;
		logic [27:0]  end_pos;
		int           mismatches;

		function new();
			play_mode  = wtlr_pkg::MODE_ONESHOT;
			pitch      = wtlr_pkg::PITCH_STEP_RST;
			loop_lo    = '0;
			loop_hi    = '0;
			end_pos    = '0;
			pos        = '0;
			reverse    = 1'b0;
			playing    = 1'b0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [27:0] data);
			case (idx)
			wtlr_pkg::CFG_LOOP_MODE:  play_mode = data[1:0];
			wtlr_pkg::CFG_PITCH_STEP: pitch = data[23:0];
			wtlr_pkg::CFG_LOOP_START: loop_lo = data;
			wtlr_pkg::CFG_LOOP_END:   loop_hi = data;
			wtlr_pkg::CFG_SAMPLE_END: end_pos = data;
			default: ;
			endcase
		endfunction

		// interpolate at the current position, then step the position
		function wave_sample_t render_sample();
			wave_sample_t r;
			longint       p, a, b, f, st, lo, hi, fin;
			logic [15:0]  idx, nxt;
			r.sample = '0;
			if (playing) begin
				idx = pos[27:POS_FRAC];
				nxt = idx + 16'd1;
				f   = longint'(pos[POS_FRAC-1:0]);
				a   = longint'($signed(wave_words[idx]));
				if (f != 0) begin
					b = longint'($signed(wave_words[nxt]));
					a = a + (((b - a) * f) >>> POS_FRAC);
				end
				r.sample = a[15:0];
				p   = longint'(pos);
				st  = longint'(pitch);
				lo  = longint'(loop_lo);
				hi  = longint'(loop_hi);
				fin = longint'(end_pos);
				case (play_mode)
				wtlr_pkg::MODE_ONESHOT: begin
					p = p + st;
					// past the end: voice stops, position is kept
					if (p > fin)
						playing = 1'b0;
					else
						pos = p[27:0];
				end
				wtlr_pkg::MODE_LOOP: begin
					p = p + st;
					if (p > hi)
						p = p - (hi - lo);
					pos = p[27:0];
				end
				default: begin
					if (!reverse) begin
						p = p + st;
						if (p > hi) begin
							p       = 2 * hi - p;
							reverse = 1'b1;
						end
					end else begin
						p = p - st;
						if (p < lo) begin
							p       = 2 * lo - p;
							reverse = 1'b0;
						end
					end
					pos = p[27:0];
				end
				endcase
			end
			r.active = playing;
			return r;
		endfunction

		function void note_word(logic [1:0] req, logic [15:0] idx, logic [15:0] val,
				logic [27:0] start);
			case (req)
			wtlr_pkg::REQ_LOAD:    wave_words[idx] = val;
			wtlr_pkg::REQ_START: begin
				pos     = start;
				reverse = 1'b0;
				playing = 1'b1;
			end
			wtlr_pkg::REQ_PRODUCE: expected_samples.push_back(render_sample());
			default: ;
			endcase
		endfunction

		function void check_sample(logic [15:0] sample, logic active);
			wave_sample_t e;
			if (expected_samples.size() == 0) begin
				$error("sample word with nothing expected: sample_out %0d voice_active %0b",
					$signed(sample), active);
				mismatches++;
				return;
			end
			e = expected_samples.pop_front();
			if (sample !== e.sample) begin
				$error("sample_out: expected %0d, actual %0d", $signed(e.sample),
					$signed(sample));
				mismatches++;
			end
			if (active !== e.active) begin
				$error("voice_active: expected %0b, actual %0b", e.active, active);
				mismatches++;
			end
		endfunction
	endclass

endpackage

// ===== test/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Testbench of the wavetable loop resampler. A directed part covers the
// word extremes, address wrap, every play mode and the end handling; then
// random phases reprogram the voice while idle and play start-and-run
// sequences with random gaps and output stall, checked word by word.
// ---------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import wtlr_pkg::*;
	import resampler_tb_pkg::*;

	localparam int DRAIN_CYCLES   = 6;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES         = 12;
	localparam int PHASE_WORDS    = 163;

	logic                 clk            = 1'b0;
	logic                 arst_n         = 1'b0;
	logic                 cfg_write      = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index      = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;
	logic                 in_valid       = 1'b0;
	logic                 in_stall;
	logic [REQ_W-1:0]     req_type       = '0;
	logic [WORD_W-1:0]    word_index     = '0;
	logic signed [WORD_W-1:0] word_value = '0;
	logic [CPOS_W-1:0]    start_position = '0;
	logic                 out_valid;
	logic                 out_stall      = 1'b0;
	logic signed [WORD_W-1:0] sample_out;
	logic                 voice_active;

	voice_scoreboard sb = new();
	int gap_pct     = 0;
	int stall_pct   = 0;
	int words_sent  = 0;
	int quiet_cycles = 0;

	wavetable_loop_resampler u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_sample(sample_out, voice_active);
		out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

	// valid stays up after acceptance; the next word or a hold-off decides
	task automatic send_word(logic [1:0] req, logic [15:0] idx, logic [15:0] val,
			logic [27:0] start);
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		req_type       <= req;
		word_index     <= idx;
		word_value     <= val;
		start_position <= start;
		do @(posedge clk); while (in_stall);
		sb.note_word(req, idx, val, start);
		if (req != REQ_IGNORED)
			words_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_samples.size() != 0)
			@(posedge clk);
		// loads and starts leave no result behind them
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [27:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic program_voice(logic [1:0] mode, logic [23:0] step, logic [27:0] lo,
			logic [27:0] hi, logic [27:0] fin);
		write_reg(CFG_LOOP_MODE, 28'(mode));
		write_reg(CFG_PITCH_STEP, 28'(step));
		write_reg(CFG_LOOP_START, lo);
		write_reg(CFG_LOOP_END, hi);
		write_reg(CFG_SAMPLE_END, fin);
		cfg_write <= 1'b0;
	endtask

	// produce one sample; words the voice is about to read get loaded first
	task automatic play_one();
		logic [15:0] idx, nxt;
		if (sb.playing) begin
			idx = sb.pos[27:POS_FRAC];
			nxt = idx + 16'd1;
			if (!sb.wave_words.exists(idx))
				send_word(REQ_LOAD, idx, 16'($urandom()), 28'($urandom()));
			if (sb.pos[POS_FRAC-1:0] != 0 && !sb.wave_words.exists(nxt))
				send_word(REQ_LOAD, nxt, 16'($urandom()), 28'($urandom()));
		end
		send_word(REQ_PRODUCE, 16'($urandom()), 16'($urandom()), 28'($urandom()));
	endtask

	task automatic program_random();
		logic [1:0]  mode;
		logic [23:0] step;
		logic [27:0] lo, hi, fin;
		mode = 2'($urandom_range(0, 3));
		case ($urandom_range(0, 9))
		0: step = '0;
		1: step = '1;
		2: step = 24'($urandom());
		default: step = 24'($urandom_range(1, 12288));
		endcase
		lo  = 28'($urandom());
		hi  = lo + 28'($urandom_range(0, 48 * 4096));
		fin = lo + 28'($urandom_range(0, 64 * 4096));
		case ($urandom_range(0, 9))
		0: begin
			lo = '0;
			hi = '1;
		end
		1: {lo, hi} = {hi, lo};
		2: fin = '1;
		3: fin = '0;
		default: ;
		endcase
		program_voice(mode, step, lo, hi, fin);
	endtask

	task automatic play_random(int count);
		int          target;
		int          r;
		logic [27:0] start;
		target = words_sent + count;
		while (words_sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				send_word(REQ_LOAD, 16'($urandom()), 16'($urandom()), 28'($urandom()));
			end else if (r < 11) begin
				send_word(REQ_IGNORED, 16'($urandom()), 16'($urandom()),
					28'($urandom()));
			end else if (r < 13) begin
				wait_drained();
			end else if (r < 17) begin
				play_one();
			end else begin
				if (sb.loop_lo <= sb.loop_hi && $urandom_range(0, 3) != 0)
					start = sb.loop_lo +
						28'($urandom_range(0, 32'(sb.loop_hi - sb.loop_lo)));
				else
					start = 28'($urandom());
				send_word(REQ_START, 16'($urandom()), 16'($urandom()), start);
				repeat ($urandom_range(1, 24)) play_one();
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gap_pct   = 16;
		stall_pct = 49;

		// reset registers: one-shot with sample end zero
		send_word(REQ_LOAD, 16'h0000, 16'h8000, 28'h0000000);
		send_word(REQ_LOAD, 16'hFFFF, 16'h7FFF, 28'hFFFFFFF);
		send_word(REQ_PRODUCE, 16'h0000, 16'h0000, 28'h0000000);
		send_word(REQ_IGNORED, 16'hFFFF, 16'hFFFF, 28'hFFFFFFF);
		// neighbor of the top entry wraps to entry zero
		send_word(REQ_START, 16'h0000, 16'h0000, 28'hFFFF800);
		play_one();
		play_one();
		wait_drained();

		program_voice(MODE_LOOP, 24'h001800, 28'h0001000, 28'h0003000, 28'h0000000);
		send_word(REQ_START, 16'h0001, 16'h0001, 28'h0001000);
		repeat (4) play_one();
		wait_drained();

		// reflects at the loop end, then at the loop start
		program_voice(MODE_MIRROR, 24'h000C00, 28'h0001000, 28'h0002800, 28'h0000000);
		send_word(REQ_START, 16'h0002, 16'h0002, 28'h0002000);
		repeat (4) play_one();
		wait_drained();

		program_voice(MODE_MIRROR_ALT, 24'hFFFFFF, 28'h0000000, 28'h1800000,
			28'h0000000);
		send_word(REQ_START, 16'h0003, 16'h0003, 28'h0000000);
		repeat (4) play_one();
		wait_drained();

		program_voice(MODE_ONESHOT, 24'h000000, 28'h0000000, 28'hFFFFFFF, 28'hFFFFFFF);
		send_word(REQ_START, 16'h0004, 16'h0004, 28'h0000800);
		repeat (2) play_one();

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph < PHASES / 3) begin
				gap_pct   = 16;
				stall_pct = 49;
			end else if (ph < 2 * PHASES / 3) begin
				gap_pct   = 49;
				stall_pct = 16;
			end else begin
				gap_pct   = 0;
				stall_pct = 0;
			end
			wait_drained();
			program_random();
			play_random(PHASE_WORDS);
		end
		wait_drained();

		if (sb.mismatches == 0 && sb.expected_samples.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
